>>> rtl/lgs_pkg.sv
// package: shared constants, codes and types of the grid solver
`default_nettype none
package lgs_pkg;
	// default grid side
	localparam int LGS_GRID_SIZE = 256;
	// width of size comparisons, wide enough for any grid side up to 1024
	localparam int SIZE_W = 12;
	// payload widths
	localparam int CMD_W = 2;
	localparam int RC_W = 8;
	localparam int VAL_W = 32;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;
	localparam int SWEEP_W = 16;
	localparam int ASIZE_W = 9;

	// commands
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SIZE = 4'd1;

	// register reset values
	localparam logic [SWEEP_W-1:0] SWEEP_COUNT_RST = 16'd1000;
	localparam logic [ASIZE_W-1:0] ACTIVE_SIZE_RST = 9'd256;

	// status codes
	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// control from the sequencer to the grid memory
	typedef struct packed {
		logic we;
		logic re;
	} lgs_ram_ctl_t;
endpackage
`default_nettype wire

>>> rtl/lgs_ifs.sv
// interfaces: command channel, result channel and register write channel
`default_nettype none
interface lgs_cmd_if;
	import lgs_pkg::*;
	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [RC_W-1:0] row;
	logic [RC_W-1:0] col;
	logic signed [VAL_W-1:0] node_value;
	modport source (output valid, command, row, col, node_value, input ready);
	modport sink (input valid, command, row, col, node_value, output ready);
endinterface

interface lgs_res_if;
	import lgs_pkg::*;
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] read_value;
	logic status;
	modport source (output valid, read_value, status, input ready);
	modport sink (input valid, read_value, status, output ready);
endinterface

interface lgs_cfg_if;
	import lgs_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/lgs_grid_ram.sv
// grid memory: one write port, two registered read ports
`default_nettype none
module lgs_grid_ram
	import lgs_pkg::*;
#(
	parameter int ADDR_W = 16
) (
	input wire logic clk,
	input wire lgs_ram_ctl_t ctl,
	input wire logic [ADDR_W-1:0] waddr,
	input wire logic signed [VAL_W-1:0] wdata,
	input wire logic [ADDR_W-1:0] raddr_a,
	input wire logic [ADDR_W-1:0] raddr_b,
	output logic signed [VAL_W-1:0] rdata_a,
	output logic signed [VAL_W-1:0] rdata_b
);
	localparam int DEPTH = 1 << ADDR_W;

	logic signed [VAL_W-1:0] mem [DEPTH];
	logic signed [VAL_W-1:0] rdata_a_q;
	logic signed [VAL_W-1:0] rdata_b_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_a_q <= mem[raddr_a];
			rdata_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;
endmodule
`default_nettype wire

>>> rtl/laplace_gauss_seidel_grid_solver_top.sv
// Throughput: one write per cycle while the result channel is not stalled; no command is
// taken until a read's result is set. A run takes one interior node at a time, in steps set
// by the two-port grid memory (up/down, then left/right, then write back).
// Reset: clears registers at once, then a clearing pass writes zero to every grid entry,
// with no command accepted.
// Register writes are taken at all times.
`default_nettype none
module laplace_gauss_seidel_grid_solver_top
	import lgs_pkg::*;
#(
	parameter int GRID_SIZE = LGS_GRID_SIZE
) (
	input wire logic clk,
	input wire logic arst_n,
	lgs_cmd_if.sink in_ch,
	lgs_res_if.source out_ch,
	lgs_cfg_if.sink cfg
);
	localparam int IW = $clog2(GRID_SIZE);
	localparam int AW = 2 * IW;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_RUD = 3'd3;
	localparam logic [2:0] ST_RLR = 3'd4;
	localparam logic [2:0] ST_WR = 3'd5;

	logic [2:0] state_q;
	logic [AW-1:0] clr_q;
	logic [SWEEP_W-1:0] sweep_count_q;
	logic [ASIZE_W-1:0] active_size_q;
	logic [SWEEP_W-1:0] sweeps_left_q;
	logic [IW-1:0] r_q;
	logic [IW-1:0] c_q;
	logic signed [VAL_W:0] sum_ud_q;
	logic out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic out_status_q;

	logic [SIZE_W-1:0] eff_size;
	logic [SIZE_W-1:0] last_idx;
	logic in_range;
	logic out_free;
	logic accept;
	logic [AW-1:0] host_addr;
	logic signed [VAL_W+1:0] sum_all;
	logic signed [VAL_W-1:0] avg;
	logic last_c;
	logic last_r;
	logic run_empty;
	logic set_out;
	logic signed [VAL_W-1:0] set_value;
	logic set_status;

	lgs_ram_ctl_t ram_ctl;
	logic [AW-1:0] waddr;
	logic signed [VAL_W-1:0] wdata;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic signed [VAL_W-1:0] rdata_a;
	logic signed [VAL_W-1:0] rdata_b;

	// effective size and range check
	always_comb begin
		if (SIZE_W'(active_size_q) < SIZE_W'(GRID_SIZE)) begin
			eff_size = SIZE_W'(active_size_q);
		end else begin
			eff_size = SIZE_W'(GRID_SIZE);
		end
	end
	assign last_idx = eff_size - SIZE_W'(2);
	assign in_range = (SIZE_W'(in_ch.row) < eff_size) && (SIZE_W'(in_ch.col) < eff_size);
	assign host_addr = {IW'(in_ch.row), IW'(in_ch.col)};
	assign run_empty = (eff_size < SIZE_W'(3)) || (sweep_count_q == '0);

	// handshakes
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign accept = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;

	// stencil arithmetic: exact sum, floor quarter by dropping two bits
	assign sum_all = (VAL_W+2)'(sum_ud_q) + (VAL_W+2)'(rdata_a) + (VAL_W+2)'(rdata_b);
	assign avg = sum_all[VAL_W+1:2];
	assign last_c = (SIZE_W'(c_q) == last_idx);
	assign last_r = (SIZE_W'(r_q) == last_idx);

	// memory access selection
	always_comb begin
		ram_ctl = '0;
		waddr = host_addr;
		wdata = in_ch.node_value;
		raddr_a = host_addr;
		raddr_b = host_addr;
		unique case (state_q)
			ST_CLEAR: begin
				ram_ctl.we = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_IDLE: begin
				ram_ctl.we = accept && (in_ch.command == CMD_WRITE) && in_range;
				ram_ctl.re = accept && (in_ch.command == CMD_READ);
			end
			ST_RUD: begin
				ram_ctl.re = 1'b1;
				raddr_a = {r_q - IW'(1), c_q};
				raddr_b = {r_q + IW'(1), c_q};
			end
			ST_RLR: begin
				ram_ctl.re = 1'b1;
				raddr_a = {r_q, c_q - IW'(1)};
				raddr_b = {r_q, c_q + IW'(1)};
			end
			ST_WR: begin
				ram_ctl.we = 1'b1;
				waddr = {r_q, c_q};
				wdata = avg;
			end
			default: begin
			end
		endcase
	end

	// result production
	always_comb begin
		set_out = 1'b0;
		set_value = '0;
		set_status = STATUS_DONE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (in_ch.command == CMD_WRITE) begin
						set_out = 1'b1;
						set_status = in_range ? STATUS_DONE : STATUS_RANGE;
					end else if (in_ch.command == CMD_READ) begin
						set_out = !in_range;
						set_status = STATUS_RANGE;
					end else if (in_ch.command == CMD_RUN) begin
						set_out = run_empty;
					end else begin
						set_out = 1'b1;
					end
				end
			end
			ST_READ: begin
				set_out = 1'b1;
				set_value = rdata_a;
			end
			ST_WR: begin
				set_out = last_c && last_r && (sweeps_left_q == SWEEP_W'(1));
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			sweeps_left_q <= '0;
			r_q <= '0;
			c_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_ch.command == CMD_READ && in_range) begin
							state_q <= ST_READ;
						end else if (in_ch.command == CMD_RUN && !run_empty) begin
							state_q <= ST_RUD;
							sweeps_left_q <= sweep_count_q;
							r_q <= IW'(1);
							c_q <= IW'(1);
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				ST_RUD: begin
					state_q <= ST_RLR;
				end
				ST_RLR: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					state_q <= ST_RUD;
					if (last_c) begin
						c_q <= IW'(1);
						if (last_r) begin
							r_q <= IW'(1);
							sweeps_left_q <= sweeps_left_q - SWEEP_W'(1);
							if (sweeps_left_q == SWEEP_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end else begin
							r_q <= r_q + IW'(1);
						end
					end else begin
						c_q <= c_q + IW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// partial sum of the vertical neighbours
	always_ff @(posedge clk) begin
		if (state_q == ST_RLR) begin
			sum_ud_q <= (VAL_W+1)'(rdata_a) + (VAL_W+1)'(rdata_b);
		end
	end

	// registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_count_q <= SWEEP_COUNT_RST;
			active_size_q <= ACTIVE_SIZE_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_SWEEP_COUNT) begin
				sweep_count_q <= cfg.data;
			end else if (cfg.index == REG_ACTIVE_SIZE) begin
				active_size_q <= cfg.data[ASIZE_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (set_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (set_out) begin
			out_value_q <= set_value;
			out_status_q <= set_status;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.read_value = out_value_q;
	assign out_ch.status = out_status_q;

	lgs_grid_ram #(
		.ADDR_W(AW)
	) u_ram (
		.clk(clk),
		.ctl(ram_ctl),
		.waddr(waddr),
		.wdata(wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);
endmodule
`default_nettype wire

>>> rtl/lgs_checker.sv
// checker on the top level ports, bound to the top level
`default_nettype none
module lgs_checker
	import lgs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [CMD_W-1:0] command,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [VAL_W-1:0] read_value,
	input wire logic status
);
	// a result waits until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(read_value) && $stable(status))
		else $error("result payload changed while stalled");

	// no command taken while a result is stalled
	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("command taken with result stalled");

	// a node write answers in the next cycle
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == CMD_WRITE) |=> out_valid && (read_value == '0))
		else $error("node write result missing");
endmodule

bind laplace_gauss_seidel_grid_solver_top lgs_checker u_lgs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.command(in_ch.command),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.read_value(out_ch.read_value),
	.status(out_ch.status)
);
`default_nettype wire
